### design/fctab_pkg.sv
package fctab_pkg;

   // Byte addresses produced by entry arithmetic span up to 17 bits.
   localparam int ADDR_W = 17;
   localparam int PTR_W  = 17;

   localparam logic [2:0] OP_LOAD_BYTE  = 3'd0;
   localparam logic [2:0] OP_READ_BYTE  = 3'd1;
   localparam logic [2:0] OP_READ_ENTRY = 3'd2;
   localparam logic [2:0] OP_LINK       = 3'd3;
   localparam logic [2:0] OP_ALLOCATE   = 3'd4;
   localparam logic [2:0] OP_COUNT      = 3'd5;

   localparam logic [1:0] CLS_FREE  = 2'd0;
   localparam logic [1:0] CLS_CHAIN = 2'd1;
   localparam logic [1:0] CLS_BAD   = 2'd2;
   localparam logic [1:0] CLS_LAST  = 2'd3;

   localparam int         CSR_INDEX_W = 1;
   localparam logic       CSR_MODE    = 1'b0;
   localparam logic       CSR_COUNT   = 1'b1;

   localparam logic [15:0]      COUNT_RESET = 16'd355;
   localparam logic [PTR_W-1:0] PTR_RESET   = 17'd2;
   localparam logic [PTR_W-1:0] PTR_MAX     = 17'h1FFFF;

   localparam logic [15:0] LAST12  = 16'h0FFF;
   localparam logic [15:0] LMASK12 = 16'h0FF8;
   localparam logic [15:0] BMASK12 = 16'h0FF0;
   localparam logic [15:0] LAST16  = 16'hFFFF;
   localparam logic [15:0] LMASK16 = 16'hFFF8;
   localparam logic [15:0] BMASK16 = 16'hFFF0;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [15:0] cluster;
      logic [15:0] link_value;
      logic [14:0] byte_address;
      logic [7:0]  byte_in;
   } req_type;

   typedef struct packed {
      logic [15:0] entry_value;
      logic [1:0]  entry_class;
      logic [7:0]  byte_out;
      logic        table_full;
      logic [15:0] free_total;
      logic [15:0] bad_total;
   } rsp_type;

   typedef struct packed {
      logic [15:0] value;
      logic [1:0]  cls;
   } norm_type;

   // Maps a raw entry to its normalized successor and class.
   function automatic norm_type normalize(input logic [15:0] raw, input logic wide);
      logic [15:0] last;
      logic [15:0] lmask;
      logic [15:0] bmask;
      norm_type    res;
      last  = wide ? LAST16  : LAST12;
      lmask = wide ? LMASK16 : LMASK12;
      bmask = wide ? BMASK16 : BMASK12;
      if ((raw & lmask) == lmask) begin
         res.value = last;
         res.cls   = CLS_LAST;
      end else if ((raw & bmask) == bmask) begin
         res.value = bmask;
         res.cls   = CLS_BAD;
      end else begin
         res.value = raw;
         res.cls   = (raw == 16'h0000) ? CLS_FREE : CLS_CHAIN;
      end
      return res;
   endfunction

endpackage

### design/fctab_ram.sv
module fctab_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/fat_cluster_table_engine_top.sv
// Allocation-table engine for FAT12/FAT16 style cluster chains.
// A command transfers in when start is high and busy is low; the fields travel
// in req_data. busy stays high until the single result of that command has
// been shown: rsp_valid is high for exactly one cycle with the result in
// rsp_data, and the receiver cannot hold it off. Every command gives one result.
// All table bytes sit in one single-port-write, registered-read byte RAM, and
// one sequencer walks it. Read entry, allocate and count fetch each entry's
// low byte, then its high byte, then evaluate it: two byte reads through the
// single RAM read port. Allocate examines clusters from the allocation pointer
// on; count examines every cluster from 2 up to cluster_count. Link reads a
// byte and then writes the two entry bytes.
// The configuration channel (csr_valid/csr_ready, csr_index, csr_data) is
// ready whenever busy is low. Reset sets 12-bit mode, a cluster count of 355
// and an allocation pointer of 2; the table contents are not cleared and must
// be loaded before they are read.
module fat_cluster_table_engine_top #(
   parameter int TABLE_BYTES = 32768
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  fctab_pkg::req_type                   req_data,
   output logic                                 rsp_valid,
   output fctab_pkg::rsp_type                   rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [fctab_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [15:0]                          csr_data
);

   localparam int RAM_AW = $clog2(TABLE_BYTES);
   localparam logic [fctab_pkg::ADDR_W:0] LIMIT = (fctab_pkg::ADDR_W + 1)'(TABLE_BYTES);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_BYTE,
      S_FETCH_LO,
      S_FETCH_HI,
      S_EVAL,
      S_LINK_RD,
      S_LINK_W0,
      S_LINK_W1
   } state_type;

   state_type                          state_ff, state_in;
   logic                               busy_ff, busy_in;
   fctab_pkg::req_type                 req_ff, req_in;
   logic [fctab_pkg::PTR_W-1:0]        cur_ff, cur_in;
   logic [fctab_pkg::PTR_W-1:0]        ptr_ff, ptr_in;
   logic                               mode_ff, mode_in;
   logic [15:0]                        ccount_ff, ccount_in;
   logic [7:0]                         lo_ff, lo_in;
   logic [15:0]                        free_ff, free_in;
   logic [15:0]                        bad_ff, bad_in;
   logic                               rd_ok_ff, rd_ok_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   fctab_pkg::rsp_type                 rsp_ff, rsp_in;

   fctab_pkg::rsp_type                 result;
   logic                               done;
   logic                               wr_en;
   logic [fctab_pkg::ADDR_W-1:0]       wr_addr;
   logic [7:0]                         wr_data;
   logic [fctab_pkg::ADDR_W-1:0]       rd_addr;
   logic [7:0]                         ram_rd_data;
   logic [7:0]                         rd_byte;
   logic                               wr_ok;

   logic [14:0]                        half;
   logic [fctab_pkg::ADDR_W-1:0]       a3, a3p1, a3p2;
   logic [fctab_pkg::ADDR_W-1:0]       a_lo, a_hi;
   logic [fctab_pkg::ADDR_W-1:0]       byte_addr;
   logic [15:0]                        raw;
   fctab_pkg::norm_type                norm;
   logic [15:0]                        free_nx, bad_nx;
   logic [15:0]                        lv;
   logic [fctab_pkg::PTR_W-1:0]        cc_wide;

   // Entry byte addresses. A 16-bit entry sits at 2n and 2n+1. A pair of
   // 12-bit entries shares three bytes starting at 3*(n/2); the odd entry
   // owns the upper nibble of the middle byte and the even one the lower.
   assign half = cur_ff[15:1];
   assign a3   = fctab_pkg::ADDR_W'({half, 1'b0}) + fctab_pkg::ADDR_W'(half);
   assign a3p1 = a3 + 17'd1;
   assign a3p2 = a3 + 17'd2;

   always_comb begin
      if (mode_ff) begin
         a_lo = {cur_ff[15:0], 1'b0};
         a_hi = {cur_ff[15:0], 1'b1};
      end else if (cur_ff[0]) begin
         a_lo = a3p1;
         a_hi = a3p2;
      end else begin
         a_lo = a3;
         a_hi = a3p1;
      end
   end

   assign byte_addr = {2'b00, req_ff.byte_address};
   assign cc_wide   = {1'b0, ccount_ff};
   assign lv        = req_ff.link_value;

   // Bytes that lie beyond the table read as zero.
   assign rd_byte = rd_ok_ff ? ram_rd_data : 8'h00;

   // The high byte is arriving from the RAM while the entry is evaluated.
   always_comb begin
      if (mode_ff) begin
         raw = {rd_byte, lo_ff};
      end else if (cur_ff[0]) begin
         raw = {4'h0, rd_byte, lo_ff[7:4]};
      end else begin
         raw = {4'h0, rd_byte[3:0], lo_ff};
      end
   end

   assign norm    = fctab_pkg::normalize(raw, mode_ff);
   assign free_nx = free_ff + ((norm.cls == fctab_pkg::CLS_FREE) ? 16'd1 : 16'd0);
   assign bad_nx  = bad_ff + ((norm.cls == fctab_pkg::CLS_BAD) ? 16'd1 : 16'd0);

   assign rd_ok_in = ({1'b0, rd_addr} < LIMIT);
   assign wr_ok    = ({1'b0, wr_addr} < LIMIT);

   always_comb begin
      state_in     = state_ff;
      busy_in      = busy_ff;
      req_in       = req_ff;
      cur_in       = cur_ff;
      ptr_in       = ptr_ff;
      mode_in      = mode_ff;
      ccount_in    = ccount_ff;
      lo_in        = lo_ff;
      free_in      = free_ff;
      bad_in       = bad_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      result       = '0;
      done         = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = a_lo;
      wr_data      = 8'h00;
      rd_addr      = a_lo;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            fctab_pkg::CSR_MODE:  mode_in   = csr_data[0];
            fctab_pkg::CSR_COUNT: ccount_in = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_data;
               cur_in   = {1'b0, req_data.cluster};
               busy_in  = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (req_ff.opcode)
               fctab_pkg::OP_LOAD_BYTE: begin
                  wr_en   = 1'b1;
                  wr_addr = byte_addr;
                  wr_data = req_ff.byte_in;
                  done    = 1'b1;
               end
               fctab_pkg::OP_READ_BYTE: begin
                  rd_addr  = byte_addr;
                  state_in = S_BYTE;
               end
               fctab_pkg::OP_READ_ENTRY: begin
                  state_in = S_FETCH_LO;
               end
               fctab_pkg::OP_LINK: begin
                  state_in = S_LINK_RD;
               end
               fctab_pkg::OP_ALLOCATE: begin
                  if (ptr_ff > cc_wide) begin
                     result.table_full = 1'b1;
                     ptr_in = (ptr_ff < fctab_pkg::PTR_MAX) ? ptr_ff + 17'd1 : ptr_ff;
                     done   = 1'b1;
                  end else begin
                     cur_in   = ptr_ff;
                     state_in = S_FETCH_LO;
                  end
               end
               fctab_pkg::OP_COUNT: begin
                  free_in = 16'd0;
                  bad_in  = 16'd0;
                  if (ccount_ff < 16'd2) begin
                     done = 1'b1;
                  end else begin
                     cur_in   = fctab_pkg::PTR_RESET;
                     state_in = S_FETCH_LO;
                  end
               end
               default: begin
                  done = 1'b1;
               end
            endcase
         end
         S_BYTE: begin
            result.byte_out = rd_byte;
            done            = 1'b1;
         end
         S_FETCH_LO: begin
            rd_addr  = a_lo;
            state_in = S_FETCH_HI;
         end
         S_FETCH_HI: begin
            rd_addr  = a_hi;
            lo_in    = rd_byte;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            unique case (req_ff.opcode)
               fctab_pkg::OP_READ_ENTRY: begin
                  result.entry_value = norm.value;
                  result.entry_class = norm.cls;
                  done               = 1'b1;
               end
               fctab_pkg::OP_ALLOCATE: begin
                  if (norm.cls == fctab_pkg::CLS_FREE) begin
                     result.entry_value = cur_ff[15:0];
                     ptr_in             = cur_ff + 17'd1;
                     done               = 1'b1;
                  end else if (cur_ff >= cc_wide) begin
                     // The scan reached the last cluster without finding a free one.
                     result.table_full = 1'b1;
                     ptr_in            = cur_ff + 17'd2;
                     done              = 1'b1;
                  end else begin
                     cur_in   = cur_ff + 17'd1;
                     state_in = S_FETCH_LO;
                  end
               end
               fctab_pkg::OP_COUNT: begin
                  free_in = free_nx;
                  bad_in  = bad_nx;
                  if (cur_ff == cc_wide) begin
                     result.free_total = free_nx;
                     result.bad_total  = bad_nx;
                     done              = 1'b1;
                  end else begin
                     cur_in   = cur_ff + 17'd1;
                     state_in = S_FETCH_LO;
                  end
               end
               default: begin
                  done = 1'b1;
               end
            endcase
         end
         S_LINK_RD: begin
            // Fetch the byte shared with the neighbor entry in 12-bit mode.
            rd_addr  = cur_ff[0] ? a_lo : a_hi;
            state_in = S_LINK_W0;
         end
         S_LINK_W0: begin
            wr_en = 1'b1;
            if (mode_ff) begin
               wr_addr = a_lo;
               wr_data = lv[7:0];
            end else if (cur_ff[0]) begin
               wr_addr = a_lo;
               wr_data = {lv[3:0], ram_rd_data[3:0]};
            end else begin
               wr_addr = a_hi;
               wr_data = {ram_rd_data[7:4], lv[11:8]};
            end
            state_in = S_LINK_W1;
         end
         S_LINK_W1: begin
            wr_en = 1'b1;
            if (mode_ff) begin
               wr_addr = a_hi;
               wr_data = lv[15:8];
            end else if (cur_ff[0]) begin
               wr_addr = a_hi;
               wr_data = lv[11:4];
            end else begin
               wr_addr = a_lo;
               wr_data = lv[7:0];
            end
            done = 1'b1;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (done) begin
         rsp_in       = result;
         rsp_valid_in = 1'b1;
         busy_in      = 1'b0;
         state_in     = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         busy_ff      <= 1'b0;
         ptr_ff       <= fctab_pkg::PTR_RESET;
         mode_ff      <= 1'b0;
         ccount_ff    <= fctab_pkg::COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         ptr_ff       <= ptr_in;
         mode_ff      <= mode_in;
         ccount_ff    <= ccount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff   <= req_in;
      cur_ff   <= cur_in;
      lo_ff    <= lo_in;
      free_ff  <= free_in;
      bad_ff   <= bad_in;
      rd_ok_ff <= rd_ok_in;
      rsp_ff   <= rsp_in;
   end

   fctab_ram #(
      .WIDTH (8),
      .DEPTH (TABLE_BYTES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en && wr_ok),
      .wr_addr (wr_addr[RAM_AW-1:0]),
      .wr_data (wr_data),
      .rd_addr (rd_addr[RAM_AW-1:0]),
      .rd_data (ram_rd_data)
   );

   assign busy      = busy_ff;
   assign csr_ready = !busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The sequencer is idle exactly when the block reports not busy.
   a_idle_busy : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) == !busy_ff)
      else $error("busy flag disagrees with sequencer state");

   // An accepted command keeps the block busy in the next cycle.
   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy_ff) |=> busy_ff)
      else $error("command transfer did not raise busy");

   // A result is shown only once the command has finished.
   a_rsp_done : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !busy_ff && $past(busy_ff))
      else $error("result shown while busy or without a command");

   // The allocation pointer never drops below the first data cluster.
   a_ptr_floor : assert property (@(posedge clock) disable iff (reset)
      ptr_ff >= fctab_pkg::PTR_RESET)
      else $error("allocation pointer below first cluster");

   // A full table is reported only by allocate and carries no cluster.
   a_full_alloc : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.table_full) |->
         (req_ff.opcode == fctab_pkg::OP_ALLOCATE) && (rsp_ff.entry_value == 16'h0000))
      else $error("table_full outside allocate or with a cluster value");

endmodule
